/* hw/rtl/hash_table_triangular_probe_top_defines.svh */
// Assertion macros used by the hash table probe sequencer.
`ifndef HASH_TABLE_TRIANGULAR_PROBE_TOP_DEFINES_SVH
`define HASH_TABLE_TRIANGULAR_PROBE_TOP_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define HTH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define HTH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/hth_pkg.sv */
// Package with the request, result and status types of the hash table.
package hth_pkg;

  // Fixed field widths of the stream payloads.
  localparam int KEY_WORD_W   = 64;
  localparam int KEY_HASH_W   = 32;
  localparam int STORE_VAL_W  = 32;
  localparam int SLOT_INDEX_W = 10;
  localparam int READ_VAL_W   = 32;
  localparam int S_TDATA_W    = KEY_WORD_W + KEY_HASH_W + STORE_VAL_W;
  localparam int M_TDATA_W    = 48;

  // Request kinds.
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_STORE  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_ABSENT   = 2'd1,
    ST_INSERTED = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // One request as it enters the probe engine.
  typedef struct packed {
    logic                   req_type;
    logic [KEY_WORD_W-1:0]  key_word;
    logic [KEY_HASH_W-1:0]  key_hash;
    logic [STORE_VAL_W-1:0] store_value;
  } req_t;

  // One result as it leaves the probe engine.
  typedef struct packed {
    status_t                 status;
    logic [SLOT_INDEX_W-1:0] slot_index;
    logic [READ_VAL_W-1:0]   read_value;
  } result_t;

endpackage

/* hw/rtl/hth_slot_ram.sv */
// Single-port-write, single-port-read slot memory with registered read data.
module hth_slot_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 97
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/hth_probe_fsm.sv */
// Probe sequencer: clearing pass, triangular probe, update and insert.
`include "hash_table_triangular_probe_top_defines.svh"

module hth_probe_fsm #(
  parameter int CAPACITY    = 1024,
  parameter int KEY_WIDTH   = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  hth_pkg::req_t                        in_req,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output hth_pkg::result_t                     res,
  output logic                                 rd_en,
  output logic [$clog2(CAPACITY)-1:0]          rd_addr,
  input  logic [KEY_WIDTH+VALUE_WIDTH:0]       rd_data,
  output logic                                 wr_en,
  output logic [$clog2(CAPACITY)-1:0]          wr_addr,
  output logic [KEY_WIDTH+VALUE_WIDTH:0]       wr_data
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = IW + 1;
  localparam int EW = 1 + KEY_WIDTH + VALUE_WIDTH;
  localparam int SlotW = hth_pkg::SLOT_INDEX_W;
  localparam int ValW  = hth_pkg::READ_VAL_W;
  localparam logic [CW-1:0] LoadLimit = CW'((CAPACITY * 3) / 4);
  localparam logic [CW-1:0] MaxStep   = CW'(CAPACITY);
  localparam logic [IW-1:0] LastAddr  = IW'(CAPACITY - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_RESP
  } state_t;

  state_t                 state;
  logic [IW-1:0]          clr_addr;
  logic [IW-1:0]          pos;
  logic [CW-1:0]          step;
  logic                   req_is_store;
  logic [KEY_WIDTH-1:0]   req_key;
  logic [VALUE_WIDTH-1:0] req_val;
  logic [CW-1:0]          entry_count;

  logic                   ent_valid;
  logic [KEY_WIDTH-1:0]   ent_key;
  logic [VALUE_WIDTH-1:0] ent_val;
  logic                   stop;
  logic                   exhausted;
  logic                   do_insert;
  logic                   do_update;
  hth_pkg::result_t       res_next;

  // Fields of the slot that was read in the previous cycle.
  assign ent_valid = rd_data[EW-1];
  assign ent_key   = rd_data[VALUE_WIDTH +: KEY_WIDTH];
  assign ent_val   = rd_data[VALUE_WIDTH-1:0];

  // Probe decisions for the slot under test.
  assign stop      = !ent_valid || (ent_key == req_key);
  assign exhausted = (step == MaxStep);
  assign do_update = (state == S_CHECK) && stop && req_is_store && ent_valid;
  assign do_insert = (state == S_CHECK) && stop && req_is_store && !ent_valid &&
                     (entry_count < LoadLimit);

  assign in_ready = (state == S_IDLE);

  // Read address: home slot on a new request, next triangular slot while probing.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = pos + step[IW-1:0];
    unique case (state)
      S_IDLE: begin
        rd_en   = in_valid;
        rd_addr = in_req.key_hash[IW-1:0];
      end
      S_CHECK: begin
        rd_en = !stop && !exhausted;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Write port: clearing pass after reset, or the update or insert of a store.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = {1'b1, req_key, req_val};
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (do_update || do_insert) begin
      wr_en = 1'b1;
    end
  end

  // Result of the request once the probe has stopped or run out.
  always_comb begin
    res_next.status     = hth_pkg::ST_FULL;
    res_next.slot_index = '0;
    res_next.read_value = '0;
    if (!req_is_store) begin
      if (stop && ent_valid) begin
        res_next.status     = hth_pkg::ST_FOUND;
        res_next.slot_index = SlotW'(pos);
        res_next.read_value = ValW'(ent_val);
      end else begin
        res_next.status = hth_pkg::ST_ABSENT;
      end
    end else if (do_update) begin
      res_next.status     = hth_pkg::ST_FOUND;
      res_next.slot_index = SlotW'(pos);
      res_next.read_value = ValW'(req_val);
    end else if (do_insert) begin
      res_next.status     = hth_pkg::ST_INSERTED;
      res_next.slot_index = SlotW'(pos);
      res_next.read_value = ValW'(req_val);
    end
  end

  // Sequencer state and registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      entry_count <= '0;
      res_valid   <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LastAddr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req_is_store <= (in_req.req_type == hth_pkg::REQ_STORE);
            req_key      <= KEY_WIDTH'(in_req.key_word);
            req_val      <= VALUE_WIDTH'(in_req.store_value);
            pos          <= in_req.key_hash[IW-1:0];
            step         <= CW'(1);
            state        <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (stop || exhausted) begin
            res       <= res_next;
            res_valid <= 1'b1;
            state     <= S_RESP;
            if (do_insert) begin
              entry_count <= entry_count + 1'b1;
            end
          end else begin
            pos  <= rd_addr;
            step <= step + 1'b1;
          end
        end
        S_RESP: begin
          if (res_ready) begin
            res_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Occupancy never passes the load limit.
  `HTH_ASSERT(a_count_limit, entry_count <= LoadLimit, "entry count above load limit")
  // Occupancy only grows, and by one at a time.
  `HTH_ASSERT(a_count_step, (!$past(rst) && entry_count != $past(entry_count)) |-> (entry_count == $past(entry_count) + 1'b1), "entry count changed by other than one")
  // The probe step stays within one full sweep of the table.
  `HTH_ASSERT(a_step_range, (state == S_CHECK) |-> (step != '0 && step <= MaxStep), "probe step out of range")
  // A result that is not taken holds.
  `HTH_ASSERT(a_res_hold, (res_valid && !res_ready) |=> (res_valid && $stable(res)), "pending result changed")

endmodule

/* hw/rtl/hash_table_triangular_probe_top.sv */
// Top level of the open-addressed hash table with triangular probing.
//
// Requests arrive on the s_ stream: s_tuser is the request kind (0 lookup,
// 1 store) and s_tdata carries key, hash and store value. One result per
// request leaves on the m_ stream: m_tuser is the status and m_tdata holds
// the slot index and the value at that slot.
// A request is taken only while the engine is idle; it is worked on alone.
// Each probe costs one read of the slot memory, so the time from a request's
// transfer to its result grows with the number of slots probed
// (one for a key at its home slot), and the next request can be taken in the
// cycle after the result is loaded into the output register.
// After reset the slot memory is cleared one slot per cycle, all CAPACITY slots
// (1024 by default), with s_tready low until that pass is done.
// The output register lets a new request be taken while a result waits; if
// the receiver keeps m_tready low, the next result holds inside the engine
// and no further request is taken until the output register frees up.
module hash_table_triangular_probe_top #(
  parameter int CAPACITY    = 1024,
  parameter int KEY_WIDTH   = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // Fields from bit 0 up: key_word[63:0], key_hash[95:64], store_value[127:96].
  input  logic [hth_pkg::S_TDATA_W-1:0] s_tdata,
  // Fields from bit 0 up: req_type[0].
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // Fields from bit 0 up: slot_index[9:0], read_value[41:10], zero fill[47:42].
  output logic [hth_pkg::M_TDATA_W-1:0] m_tdata,
  // Fields from bit 0 up: status[1:0].
  output logic [1:0]                    m_tuser
);

  localparam int IW = $clog2(CAPACITY);
  localparam int EW = 1 + KEY_WIDTH + VALUE_WIDTH;
  localparam int PadW = hth_pkg::M_TDATA_W - hth_pkg::SLOT_INDEX_W - hth_pkg::READ_VAL_W;

  hth_pkg::req_t    in_req;
  hth_pkg::result_t res;
  logic             res_valid;
  logic             res_ready;
  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  logic [EW-1:0]    rd_data;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  logic [EW-1:0]    wr_data;

  // Unpack the request payload.
  assign in_req.req_type    = s_tuser;
  assign in_req.key_word    = s_tdata[hth_pkg::KEY_WORD_W-1:0];
  assign in_req.key_hash    = s_tdata[hth_pkg::KEY_WORD_W +: hth_pkg::KEY_HASH_W];
  assign in_req.store_value =
    s_tdata[hth_pkg::KEY_WORD_W + hth_pkg::KEY_HASH_W +: hth_pkg::STORE_VAL_W];

  hth_probe_fsm #(
    .CAPACITY    (CAPACITY),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_fsm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_req    (in_req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  hth_slot_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (EW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Output register: loads a result when empty or when its transfer completes.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tuser <= res.status;
      m_tdata <= {{PadW{1'b0}}, res.read_value, res.slot_index};
    end
  end

endmodule
